// ===== rtl/core/cejm_pkg.sv =====
// Shared types and constants for the contact event jitter merger.
// Used by contact_event_jitter_merger and its testbench; no dependencies.
`default_nettype none

package cejm_pkg;

   // Sizing defaults
   localparam int PENDING_DEPTH_DEF = 16;
   localparam int ID_BITS_DEF       = 16;

   // Fixed field widths
   localparam int OBJ_W   = 16;
   localparam int TIME_W  = 32;
   localparam int CFG_W   = 16;
   localparam int CODE_W  = 2;
   localparam int CSR_IW  = 1;

   // Input transaction kinds
   typedef enum logic [1:0] {
      KIND_BEGIN = 2'd0,
      KIND_END   = 2'd1,
      KIND_TICK  = 2'd2,
      KIND_FLUSH = 2'd3
   } kind_type;

   // Published event codes
   localparam logic [CODE_W-1:0] EVT_BEGIN = 2'd1;
   localparam logic [CODE_W-1:0] EVT_END   = 2'd2;

   // Register indexes
   localparam logic [CSR_IW-1:0] CSR_MERGE_WINDOW = 1'b0;
   localparam logic [CSR_IW-1:0] CSR_EXTRA_DELAY  = 1'b1;

   // Register reset values
   localparam logic [CFG_W-1:0] MERGE_WINDOW_RST = 16'd100;
   localparam logic [CFG_W-1:0] EXTRA_DELAY_RST  = 16'd10;

endpackage

`default_nettype wire

// ===== rtl/core/cejm_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies; holds the pending end list of the merger.
`default_nettype none

module cejm_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/contact_event_jitter_merger.sv =====
// Contact event jitter merger: top level with sequencer and shared age unit.
// Depends on cejm_pkg and cejm_ram (pending end list storage).
// Sequencing: an end, an ignored item, a begin or flush on an empty list and a tick
// before the deadline or while disarmed finish in the decide state; any other begin,
// tick or flush goes on to a scan, in which one subtract/compare unit walks the pending
// RAM one entry per cycle; busy holds off a new item until the last is done. Results
// appear one per cycle on rsp_valid; the receiver cannot stall.
// Reset (synchronous): list empty, deadline disarmed, registers 100 / 10; RAM not cleared.
`default_nettype none

module contact_event_jitter_merger #(
   parameter int PENDING_DEPTH = cejm_pkg::PENDING_DEPTH_DEF,
   parameter int ID_BITS       = cejm_pkg::ID_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // Command channel
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [1:0]                    req_kind,
   input  wire logic [cejm_pkg::OBJ_W-1:0]    req_object_id,
   input  wire logic                          req_eligible,
   input  wire logic [cejm_pkg::TIME_W-1:0]   req_now_time,
   // Result channel
   output logic                               rsp_valid,
   output logic [cejm_pkg::CODE_W-1:0]        rsp_event_code,
   output logic [cejm_pkg::OBJ_W-1:0]         rsp_object_out,
   output logic                               rsp_last,
   // Register write channel
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [cejm_pkg::CSR_IW-1:0]   csr_index,
   input  wire logic [cejm_pkg::CFG_W-1:0]    csr_wdata
);

   localparam int AW     = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
   localparam int CW     = $clog2(PENDING_DEPTH + 1);
   localparam int TW     = cejm_pkg::TIME_W;
   localparam int ENT_W  = ID_BITS + TW;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_SCAN
   } state_type;

   // Registers
   state_type                     state_ff, state_in;
   logic [cejm_pkg::CFG_W-1:0]    window_ff, window_in;
   logic [cejm_pkg::CFG_W-1:0]    extra_ff, extra_in;
   logic [CW-1:0]                 count_ff, count_in;
   logic                          armed_ff, armed_in;
   logic [TW-1:0]                 deadline_ff, deadline_in;
   cejm_pkg::kind_type            kind_ff, kind_in;
   logic [ID_BITS-1:0]            obj_ff, obj_in;
   logic                          elig_ff, elig_in;
   logic [TW-1:0]                 now_ff, now_in;
   logic [CW-1:0]                 rd_idx_ff, rd_idx_in;
   logic [CW-1:0]                 keep_ff, keep_in;
   logic                          dv_ff, dv_in;
   logic                          merged_ff, merged_in;
   logic                          held_v_ff, held_v_in;
   logic [ID_BITS-1:0]            held_obj_ff, held_obj_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [cejm_pkg::CODE_W-1:0]   rsp_code_ff, rsp_code_in;
   logic [ID_BITS-1:0]            rsp_obj_ff, rsp_obj_in;
   logic                          rsp_last_ff, rsp_last_in;

   // RAM ports
   logic                          ram_wr_en;
   logic [AW-1:0]                 ram_wr_addr;
   logic [ENT_W-1:0]              ram_wr_data;
   logic                          ram_rd_en;
   logic [ENT_W-1:0]              ram_rd_data;

   // Shared age unit
   logic [TW-1:0]                 sub_b;
   logic [TW-1:0]                 age;
   logic                          age_lt, age_eq, age_gt;
   logic [TW-1:0]                 arm_time;

   logic [ID_BITS-1:0]            ent_obj;
   logic [TW-1:0]                 ent_time;
   logic                          more_rd;
   logic                          drop;
   logic                          accept;

   cejm_ram #(
      .WIDTH (ENT_W),
      .DEPTH (PENDING_DEPTH),
      .AW    (AW)
   ) u_pending (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_idx_ff[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   assign busy           = (state_ff != ST_IDLE);
   assign accept         = start && !busy;
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_code = rsp_code_ff;
   assign rsp_object_out = cejm_pkg::OBJ_W'(rsp_obj_ff);
   assign rsp_last       = rsp_last_ff;

   assign ent_obj  = ram_rd_data[ENT_W-1:TW];
   assign ent_time = ram_rd_data[TW-1:0];

   // One subtractor: deadline check while deciding, entry age while scanning
   assign sub_b    = (state_ff == ST_DECIDE) ? deadline_ff : ent_time;
   assign age      = now_ff - sub_b;
   assign age_lt   = age < TW'(window_ff);
   assign age_eq   = age == TW'(window_ff);
   assign age_gt   = !age_lt && !age_eq;
   assign arm_time = now_ff + TW'(window_ff) + TW'(extra_ff);

   assign more_rd  = rd_idx_ff < count_ff;
   assign ram_rd_en = (state_ff == ST_SCAN) && more_rd;

   // Entry disposal during a scan
   always_comb begin
      unique case (kind_ff)
         cejm_pkg::KIND_BEGIN: drop = !merged_ff && (ent_obj == obj_ff) && age_lt;
         cejm_pkg::KIND_TICK:  drop = age_gt;
         cejm_pkg::KIND_FLUSH: drop = 1'b1;
         default:              drop = 1'b0;
      endcase
   end

   // Sequencer next state
   always_comb begin
      state_in     = state_ff;
      window_in    = window_ff;
      extra_in     = extra_ff;
      count_in     = count_ff;
      armed_in     = armed_ff;
      deadline_in  = deadline_ff;
      kind_in      = kind_ff;
      obj_in       = obj_ff;
      elig_in      = elig_ff;
      now_in       = now_ff;
      rd_idx_in    = rd_idx_ff;
      keep_in      = keep_ff;
      dv_in        = 1'b0;
      merged_in    = merged_ff;
      held_v_in    = held_v_ff;
      held_obj_in  = held_obj_ff;
      rsp_valid_in = 1'b0;
      rsp_code_in  = rsp_code_ff;
      rsp_obj_in   = rsp_obj_ff;
      rsp_last_in  = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = count_ff[AW-1:0];
      ram_wr_data  = {obj_ff, now_ff};

      // Register writes (only while idle by contract)
      if (csr_valid) begin
         unique case (csr_index)
            cejm_pkg::CSR_MERGE_WINDOW: window_in = csr_wdata;
            cejm_pkg::CSR_EXTRA_DELAY:  extra_in  = csr_wdata;
            default:                    window_in = window_ff;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in  = cejm_pkg::kind_type'(req_kind);
               obj_in   = ID_BITS'(req_object_id);
               elig_in  = req_eligible;
               now_in   = req_now_time;
               state_in = ST_DECIDE;
            end
         end

         ST_DECIDE: begin
            state_in    = ST_IDLE;
            rd_idx_in   = '0;
            keep_in     = '0;
            merged_in   = 1'b0;
            held_v_in   = 1'b0;
            unique case (kind_ff)
               cejm_pkg::KIND_BEGIN: begin
                  if (elig_ff) begin
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_code_in  = cejm_pkg::EVT_BEGIN;
                        rsp_obj_in   = obj_ff;
                        rsp_last_in  = 1'b1;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
               end
               cejm_pkg::KIND_END: begin
                  if (elig_ff) begin
                     if (count_ff == CW'(PENDING_DEPTH)) begin
                        rsp_valid_in = 1'b1;
                        rsp_code_in  = cejm_pkg::EVT_END;
                        rsp_obj_in   = obj_ff;
                        rsp_last_in  = 1'b1;
                     end else begin
                        ram_wr_en = 1'b1;
                        count_in  = count_ff + 1'b1;
                        if (!armed_ff) begin
                           armed_in    = 1'b1;
                           deadline_in = arm_time;
                        end
                     end
                  end
               end
               cejm_pkg::KIND_TICK: begin
                  // deadline reached when now - deadline is below half range
                  if (armed_ff && !age[TW-1]) begin
                     state_in = ST_SCAN;
                  end
               end
               cejm_pkg::KIND_FLUSH: begin
                  if (count_ff == '0) begin
                     armed_in = 1'b0;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end

         ST_SCAN: begin
            // issue reads one entry per cycle
            if (more_rd) begin
               rd_idx_in = rd_idx_ff + 1'b1;
               dv_in     = 1'b1;
            end

            // evaluate the entry read last cycle
            if (dv_ff) begin
               if (drop) begin
                  if (kind_ff == cejm_pkg::KIND_BEGIN) begin
                     merged_in = 1'b1;
                  end else begin
                     // hold one end back so the final one can carry last
                     if (held_v_ff) begin
                        rsp_valid_in = 1'b1;
                        rsp_code_in  = cejm_pkg::EVT_END;
                        rsp_obj_in   = held_obj_ff;
                     end
                     held_v_in   = 1'b1;
                     held_obj_in = ent_obj;
                  end
               end else begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = keep_ff[AW-1:0];
                  ram_wr_data = ram_rd_data;
                  keep_in     = keep_ff + 1'b1;
               end
            end else if (!more_rd) begin
               // scan finished: commit list and deadline
               state_in = ST_IDLE;
               count_in = keep_ff;
               unique case (kind_ff)
                  cejm_pkg::KIND_BEGIN: begin
                     if (!merged_ff) begin
                        rsp_valid_in = 1'b1;
                        rsp_code_in  = cejm_pkg::EVT_BEGIN;
                        rsp_obj_in   = obj_ff;
                        rsp_last_in  = 1'b1;
                     end else if (keep_ff == '0) begin
                        armed_in = 1'b0;
                     end
                  end
                  cejm_pkg::KIND_TICK: begin
                     if (keep_ff != '0) begin
                        armed_in    = 1'b1;
                        deadline_in = arm_time;
                     end else begin
                        armed_in = 1'b0;
                     end
                  end
                  default: begin
                     armed_in = 1'b0;
                  end
               endcase
               if (held_v_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_code_in  = cejm_pkg::EVT_END;
                  rsp_obj_in   = held_obj_ff;
                  rsp_last_in  = 1'b1;
               end
               held_v_in = 1'b0;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         window_ff    <= cejm_pkg::MERGE_WINDOW_RST;
         extra_ff     <= cejm_pkg::EXTRA_DELAY_RST;
         count_ff     <= '0;
         armed_ff     <= 1'b0;
         deadline_ff  <= '0;
         dv_ff        <= 1'b0;
         merged_ff    <= 1'b0;
         held_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         extra_ff     <= extra_in;
         count_ff     <= count_in;
         armed_ff     <= armed_in;
         deadline_ff  <= deadline_in;
         dv_ff        <= dv_in;
         merged_ff    <= merged_in;
         held_v_ff    <= held_v_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
      end
      kind_ff     <= kind_in;
      obj_ff      <= obj_in;
      elig_ff     <= elig_in;
      now_ff      <= now_in;
      rd_idx_ff   <= rd_idx_in;
      keep_ff     <= keep_in;
      held_obj_ff <= held_obj_in;
      rsp_code_ff <= rsp_code_in;
      rsp_obj_ff  <= rsp_obj_in;
   end

endmodule

`default_nettype wire

// ===== tb/contact_event_jitter_merger_test.sv =====
`timescale 1ns / 100ps
// Testbench for contact_event_jitter_merger: directed and random contact transactions,
// checked against a behavioural predictor of the pending end list and deadline timer.
// Depends on cejm_pkg and the contact_event_jitter_merger RTL.

module contact_event_jitter_merger_test;

   localparam int LIST_DEPTH  = 16;
   localparam int CYCLE_LIMIT = 400000;
   localparam int FAULT_SHOW  = 10;
   localparam int CODE_W      = cejm_pkg::CODE_W;
   localparam int OBJ_W       = cejm_pkg::OBJ_W;
   localparam int TIME_W      = cejm_pkg::TIME_W;
   localparam int CFG_W       = cejm_pkg::CFG_W;
   localparam int CSR_IW      = cejm_pkg::CSR_IW;

   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic [OBJ_W-1:0]  obj;
      logic              last;
   } contact_evt_type;

   // DUT connections, all driven to known values from time zero
   logic                clock          = 1'b0;
   logic                reset          = 1'b1;
   logic                start          = 1'b0;
   logic [1:0]          req_kind       = cejm_pkg::KIND_TICK;
   logic [OBJ_W-1:0]    req_object_id  = '0;
   logic                req_eligible   = 1'b0;
   logic [TIME_W-1:0]   req_now_time   = '0;
   logic                csr_valid      = 1'b0;
   logic [CSR_IW-1:0]   csr_index      = cejm_pkg::CSR_MERGE_WINDOW;
   logic [CFG_W-1:0]    csr_wdata      = '0;
   logic                busy;
   logic                rsp_valid;
   logic [CODE_W-1:0]   rsp_event_code;
   logic [OBJ_W-1:0]    rsp_object_out;
   logic                rsp_last;
   logic                csr_ready;

   // Predictor state
   logic [OBJ_W-1:0]    held_obj  [LIST_DEPTH];
   logic [TIME_W-1:0]   held_time [LIST_DEPTH];
   int                  held_count   = 0;
   logic                timer_armed  = 1'b0;
   logic [TIME_W-1:0]   timer_due    = '0;
   logic [CFG_W-1:0]    window_ticks = cejm_pkg::MERGE_WINDOW_RST;
   logic [CFG_W-1:0]    extra_ticks  = cejm_pkg::EXTRA_DELAY_RST;

   contact_evt_type     due_events[$];
   int                  fault_count = 0;
   int                  cycle_count = 0;
   logic                calm        = 1'b0;

   contact_event_jitter_merger u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_object_id  (req_object_id),
      .req_eligible   (req_eligible),
      .req_now_time   (req_now_time),
      .rsp_valid      (rsp_valid),
      .rsp_event_code (rsp_event_code),
      .rsp_object_out (rsp_object_out),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #4 clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Deadline is armed a full window plus the extra delay ahead
   task automatic arm_timer(input logic [TIME_W-1:0] now);
      timer_due   = now + {16'd0, window_ticks} + {16'd0, extra_ticks};
      timer_armed = 1'b1;
   endtask

   // Work out the events one accepted transaction publishes
   task automatic predict_contact(input cejm_pkg::kind_type k, input logic [OBJ_W-1:0] obj,
                                  input logic elig, input logic [TIME_W-1:0] now);
      logic [CODE_W-1:0] codes [LIST_DEPTH+1];
      logic [OBJ_W-1:0]  objs  [LIST_DEPTH+1];
      logic [TIME_W-1:0] age;
      logic [TIME_W-1:0] since_due;
      contact_evt_type   evt;
      int                n;
      int                keep;
      logic              merged;
      n = 0;
      merged = 1'b0;
      case (k)
         cejm_pkg::KIND_BEGIN: begin
            if (elig) begin
               // oldest matching end inside the window cancels this begin
               for (int i = 0; i < held_count && !merged; i++) begin
                  age = now - held_time[i];
                  if (held_obj[i] == obj && age < {16'd0, window_ticks}) begin
                     for (int j = i; j + 1 < held_count; j++) begin
                        held_obj[j]  = held_obj[j+1];
                        held_time[j] = held_time[j+1];
                     end
                     held_count--;
                     if (held_count == 0) timer_armed = 1'b0;
                     merged = 1'b1;
                  end
               end
               if (!merged) begin
                  codes[n] = cejm_pkg::EVT_BEGIN; objs[n] = obj; n++;
               end
            end
         end
         cejm_pkg::KIND_END: begin
            if (elig) begin
               if (held_count >= LIST_DEPTH) begin
                  // list full: end goes straight out
                  codes[n] = cejm_pkg::EVT_END; objs[n] = obj; n++;
               end else begin
                  held_obj[held_count]  = obj;
                  held_time[held_count] = now;
                  held_count++;
                  if (!timer_armed) arm_timer(now);
               end
            end
         end
         cejm_pkg::KIND_TICK: begin
            since_due = now - timer_due;
            if (timer_armed && !since_due[TIME_W-1]) begin
               keep = 0;
               for (int i = 0; i < held_count; i++) begin
                  age = now - held_time[i];
                  if (age > {16'd0, window_ticks}) begin
                     codes[n] = cejm_pkg::EVT_END; objs[n] = held_obj[i]; n++;
                  end else begin
                     held_obj[keep]  = held_obj[i];
                     held_time[keep] = held_time[i];
                     keep++;
                  end
               end
               held_count = keep;
               if (held_count > 0) arm_timer(now);
               else timer_armed = 1'b0;
            end
         end
         default: begin
            for (int i = 0; i < held_count; i++) begin
               codes[n] = cejm_pkg::EVT_END; objs[n] = held_obj[i]; n++;
            end
            held_count  = 0;
            timer_armed = 1'b0;
         end
      endcase
      for (int i = 0; i < n; i++) begin
         evt.code = codes[i];
         evt.obj  = objs[i];
         evt.last = (i == n - 1);
         due_events.push_back(evt);
      end
   endtask

   // Result checker: every strobe is compared with the oldest expectation
   always @(posedge clock) begin : check_results
      contact_evt_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (due_events.size() == 0) begin
            if (fault_count < FAULT_SHOW)
               $display("unexpected event: code %0d obj %h last %b",
                        rsp_event_code, rsp_object_out, rsp_last);
            fault_count <= fault_count + 1;
         end else begin
            want = due_events.pop_front();
            if (rsp_event_code !== want.code || rsp_object_out !== want.obj ||
                rsp_last !== want.last) begin
               if (fault_count < FAULT_SHOW)
                  $display("event mismatch: expected code %0d obj %h last %b, got %0d %h %b",
                           want.code, want.obj, want.last,
                           rsp_event_code, rsp_object_out, rsp_last);
               fault_count <= fault_count + 1;
            end
         end
      end
   end

   // Issue one transaction on the command channel, idling now and then
   task automatic send_contact(input cejm_pkg::kind_type k, input logic [OBJ_W-1:0] obj,
                               input logic elig, input logic [TIME_W-1:0] now);
      @(posedge clock);
      while (!calm && $urandom_range(0, 99) < 28) @(posedge clock);
      start         <= 1'b1;
      req_kind      <= k;
      req_object_id <= obj;
      req_eligible  <= elig;
      req_now_time  <= now;
      do @(posedge clock); while (busy !== 1'b0);
      start <= 1'b0;
      predict_contact(k, obj, elig, now);
   endtask

   task automatic write_reg(input logic [CSR_IW-1:0] idx, input logic [CFG_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      if (idx == cejm_pkg::CSR_MERGE_WINDOW) window_ticks = val;
      else extra_ticks = val;
   endtask

   // Drain all expected events, then give the sequencer time to go idle
   task automatic settle();
      do @(posedge clock); while (due_events.size() != 0 || busy !== 1'b0);
      repeat (40) @(posedge clock);
   endtask

   // Lone transactions: begin with nothing pending, ignored items, idle tick
   task automatic test_lone_edges();
      send_contact(cejm_pkg::KIND_BEGIN, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
      send_contact(cejm_pkg::KIND_BEGIN, 16'h0000, 1'b0, 32'h0000_0000);
      send_contact(cejm_pkg::KIND_END,   16'hFFFF, 1'b0, 32'h0000_0010);
      send_contact(cejm_pkg::KIND_TICK,  16'h5A5A, 1'b1, 32'h8000_0000);
   endtask

   // Merge across time wrap, begin at exactly the window, deadline edge and rearm
   task automatic test_merge_window();
      send_contact(cejm_pkg::KIND_END,   16'h0000, 1'b1, 32'hFFFF_FFF0);
      send_contact(cejm_pkg::KIND_BEGIN, 16'h0000, 1'b1, 32'h0000_0005);
      send_contact(cejm_pkg::KIND_END,   16'h1234, 1'b1, 32'd1000);
      send_contact(cejm_pkg::KIND_BEGIN, 16'h1234, 1'b1, 32'd1100);
      send_contact(cejm_pkg::KIND_END,   16'h00AA, 1'b1, 32'd1105);
      send_contact(cejm_pkg::KIND_TICK,  16'h0000, 1'b0, 32'd1109);
      send_contact(cejm_pkg::KIND_TICK,  16'h0000, 1'b0, 32'd1110);
      send_contact(cejm_pkg::KIND_FLUSH, 16'h0000, 1'b0, 32'd1111);
   endtask

   // Fill the list, overflow it, flush all sixteen, flush again when empty
   task automatic test_full_list();
      for (int i = 0; i < LIST_DEPTH; i++)
         send_contact(cejm_pkg::KIND_END, OBJ_W'($urandom_range(0, 65535)), 1'b1,
                      32'd2000 + i);
      send_contact(cejm_pkg::KIND_END, 16'hBEEF, 1'b1, 32'd2020);
      send_contact(cejm_pkg::KIND_FLUSH, 16'h0000, 1'b1, 32'd2021);
      send_contact(cejm_pkg::KIND_FLUSH, 16'hFFFF, 1'b1, 32'd2022);
   endtask

   // Random traffic on a small set of objects with time moving against the window
   task automatic test_random_traffic(input int count, input logic [CFG_W-1:0] win,
                                      input logic [CFG_W-1:0] ext);
      logic [OBJ_W-1:0]  ids [4];
      logic [OBJ_W-1:0]  obj;
      logic [TIME_W-1:0] clock_now;
      logic [TIME_W-1:0] stamp;
      logic              elig;
      int                sent;
      int                pick;
      settle();
      write_reg(cejm_pkg::CSR_MERGE_WINDOW, win);
      write_reg(cejm_pkg::CSR_EXTRA_DELAY, ext);
      clock_now = $urandom();
      for (int j = 0; j < 4; j++) ids[j] = OBJ_W'($urandom_range(0, 65535));
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(0, 99);
         if ($urandom_range(0, 19) == 0) clock_now += $urandom();
         else clock_now += $urandom_range(0, int'(win) / 3 + 3);
         obj  = ids[$urandom_range(0, 3)];
         if ($urandom_range(0, 9) == 0) obj = OBJ_W'($urandom_range(0, 65535));
         elig = ($urandom_range(0, 9) != 0);
         // occasional out-of-order time stamp as noise
         stamp = ($urandom_range(0, 29) == 0) ? $urandom() : clock_now;
         if (pick < 3) begin
            // burst that runs the list past full
            for (int j = 0; j <= LIST_DEPTH; j++) begin
               clock_now += $urandom_range(0, 2);
               send_contact(cejm_pkg::KIND_END, OBJ_W'($urandom_range(0, 65535)), 1'b1,
                            clock_now);
            end
            sent += LIST_DEPTH + 1;
         end else begin
            if (pick < 38)      send_contact(cejm_pkg::KIND_END,   obj, elig, stamp);
            else if (pick < 68) send_contact(cejm_pkg::KIND_BEGIN, obj, elig, stamp);
            else if (pick < 94) send_contact(cejm_pkg::KIND_TICK,  obj, elig, stamp);
            else                send_contact(cejm_pkg::KIND_FLUSH, obj, elig, stamp);
            sent++;
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_lone_edges();
      test_merge_window();
      test_full_list();
      test_random_traffic(25, 16'd0, 16'd0);
      test_random_traffic(25, 16'hFFFF, 16'hFFFF);
      test_random_traffic(30, CFG_W'($urandom_range(1, 300)), CFG_W'($urandom_range(0, 300)));
      calm = 1'b1;
      test_random_traffic(30, 16'd20, 16'd5);
      calm = 1'b0;
      test_random_traffic(30, CFG_W'($urandom_range(0, 65535)),
                          CFG_W'($urandom_range(0, 65535)));
      settle();
      if (fault_count == 0 && due_events.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/cejm_pkg.sv
rtl/core/cejm_ram.sv
rtl/core/contact_event_jitter_merger.sv
tb/contact_event_jitter_merger_test.sv
